@@ rtl/core/wave_equation_stencil_step_defines.svh @@
// Assertion macros used by the stencil RTL.
`ifndef WAVE_EQUATION_STENCIL_STEP_DEFINES_SVH
`define WAVE_EQUATION_STENCIL_STEP_DEFINES_SVH

`ifndef SYNTH
`define WES_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wes assertion failed");
`define WES_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wes assertion failed");
`else
`define WES_ASSERT_IMP(label, clk, rst, ante, cons)
`define WES_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/wes_pkg.sv @@
package wes_pkg;

  localparam int MAX_COLUMNS    = 256;
  localparam int MAX_ROWS       = 256;
  localparam int SAMPLE_BITS    = 16;
  localparam int COL_BITS       = $clog2(MAX_COLUMNS);
  localparam int CNT_BITS       = 9;
  localparam int GAIN_BITS      = 16;
  localparam int LAP_BITS       = SAMPLE_BITS + 3;
  localparam int ACC_BITS       = LAP_BITS + GAIN_BITS + 1;
  localparam int SUM_BITS       = ACC_BITS - GAIN_BITS + 2;
  localparam int ROUND_BIAS     = 2 ** (GAIN_BITS - 1);
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CNT_BITS-1:0]  COLS_RESET = CNT_BITS'(256);
  localparam logic [CNT_BITS-1:0]  ROWS_RESET = CNT_BITS'(64);
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(3277);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GRID_COLUMNS = 2'd0,
    REG_GRID_ROWS    = 2'd1,
    REG_WAVE_GAIN    = 2'd2
  } wes_reg_t;

  typedef struct packed {
    logic                       has_out;
    logic                       eof;
    logic                       left_en;
    logic                       right_en;
    logic                       up_en;
    logic [COL_BITS-1:0]        col;
    logic signed [SAMPLE_BITS-1:0] down;
    logic signed [SAMPLE_BITS-1:0] c;
    logic signed [SAMPLE_BITS-1:0] p;
    logic signed [ACC_BITS-1:0]    acc;
  } wes_token_t;

endpackage

@@ rtl/core/wes_if.sv @@
interface wes_cell_if;
  import wes_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] cur_value;
  logic signed [SAMPLE_BITS-1:0] prev_value;
  logic                          flush;

  modport source (output valid, cur_value, prev_value, flush, input ready);
  modport sink (input valid, cur_value, prev_value, flush, output ready);
endinterface

interface wes_result_if;
  import wes_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] new_value;
  logic                          end_of_frame;

  modport source (output valid, new_value, end_of_frame, input ready);
  modport sink (input valid, new_value, end_of_frame, output ready);
endinterface

@@ rtl/core/wave_equation_stencil_step.sv @@
// One time step of the 2D wave equation, five-point stencil, on a raster stream.
// cells: one beat per grid cell in raster order (cur_value, prev_value, flush),
// valid/ready handshake. After the last grid row send one more row of beats;
// they are padding and drive out the final grid row.
// results: one beat per accepted cell from the second row on, carrying the next
// height of the cell one row above; end_of_frame marks the last cell of the grid.
// Items of the first row only fill the line stores and give no beat.
// Configuration (cfg_write_en, cfg_index, cfg_data) is written between frames or
// while the block is drained: 0 grid_columns, 1 grid_rows, 2 wave_gain.
// A chain of four handshake cells (line store read, laplacian, gain multiply, round
// and saturate) carries each item from its accepted cell beat towards its result.
// Throughput: one cell per clock while results is not stalled, set by the single
// write and read per cycle of each line store.
// Reset clears the row and column position and the registers to their defaults;
// line store contents are not cleared and are rewritten by the first rows.
// When results is stalled the cells hold their items; cells.ready falls only once
// all four are occupied, and no beat is lost or repeated.
module wave_equation_stencil_step (
  input  logic                                clk,
  input  logic                                rst,
  wes_cell_if.sink                            cells,
  wes_result_if.source                        results,
  input  logic                                cfg_write_en,
  input  logic [wes_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wes_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import wes_pkg::*;

  `include "wave_equation_stencil_step_defines.svh"

  localparam logic signed [SUM_BITS-1:0] SAT_MAX = SUM_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_MIN = -SAT_MAX - SUM_BITS'(1);

  logic [CNT_BITS-1:0]  grid_columns;
  logic [CNT_BITS-1:0]  grid_rows;
  logic [GAIN_BITS-1:0] wave_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLS_RESET;
      grid_rows    <= ROWS_RESET;
      wave_gain    <= GAIN_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_data[CNT_BITS-1:0];
        REG_GRID_ROWS:    grid_rows    <= cfg_data[CNT_BITS-1:0];
        REG_WAVE_GAIN:    wave_gain    <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_BITS-1:0] column_count;
  logic [CNT_BITS-1:0] row_count;
  logic [CNT_BITS-1:0] cols;
  logic [CNT_BITS-1:0] rows;
  logic [CNT_BITS-1:0] col_full;
  logic [COL_BITS-1:0] col;
  logic                last_col;
  logic                pad_row;
  logic                eof_now;
  logic                in_fire;
  logic signed [SAMPLE_BITS-1:0] cur_z;
  logic signed [SAMPLE_BITS-1:0] prev_z;

  always_comb begin
    if (grid_columns < CNT_BITS'(2)) begin
      cols = CNT_BITS'(2);
    end else if (grid_columns > CNT_BITS'(MAX_COLUMNS)) begin
      cols = CNT_BITS'(MAX_COLUMNS);
    end else begin
      cols = grid_columns;
    end
    if (grid_rows < CNT_BITS'(2)) begin
      rows = CNT_BITS'(2);
    end else if (grid_rows > CNT_BITS'(MAX_ROWS)) begin
      rows = CNT_BITS'(MAX_ROWS);
    end else begin
      rows = grid_rows;
    end
    col_full = (column_count >= cols) ? cols - CNT_BITS'(1) : column_count;
    col      = col_full[COL_BITS-1:0];
    last_col = (col_full == cols - CNT_BITS'(1));
    pad_row  = (row_count >= rows);
    eof_now  = pad_row && last_col;
    cur_z    = (cells.flush || pad_row) ? '0 : cells.cur_value;
    prev_z   = (cells.flush || pad_row) ? '0 : cells.prev_value;
  end

  assign in_fire = cells.valid && cells.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= pad_row ? '0 : row_count + CNT_BITS'(1);
      end else begin
        column_count <= col_full + CNT_BITS'(1);
      end
    end
  end

  wes_token_t tok0;

  always_comb begin
    tok0          = '0;
    tok0.has_out  = (row_count >= CNT_BITS'(1));
    tok0.eof      = eof_now;
    tok0.left_en  = (col != '0);
    tok0.right_en = !last_col;
    tok0.up_en    = (row_count >= CNT_BITS'(2));
    tok0.col      = col;
    tok0.down     = cur_z;
  end

  logic [SAMPLE_BITS-1:0] mid_c_rd;
  logic [SAMPLE_BITS-1:0] mid_r_rd;
  logic [SAMPLE_BITS-1:0] prev_rd;
  logic [SAMPLE_BITS-1:0] upper_rd;
  logic                   s1_fire;
  wes_token_t             s1_tok;
  logic                   s1_valid;

  wes_line_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(SAMPLE_BITS)) u_mid_center (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col),
    .wdata (cur_z),
    .re    (in_fire),
    .raddr (col),
    .rdata (mid_c_rd)
  );

  wes_line_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(SAMPLE_BITS)) u_mid_right (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col),
    .wdata (cur_z),
    .re    (in_fire),
    .raddr (col + COL_BITS'(1)),
    .rdata (mid_r_rd)
  );

  wes_line_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(SAMPLE_BITS)) u_mid_prev (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col),
    .wdata (prev_z),
    .re    (in_fire),
    .raddr (col),
    .rdata (prev_rd)
  );

  wes_line_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(SAMPLE_BITS)) u_upper (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_tok.col),
    .wdata (mid_c_rd),
    .re    (in_fire),
    .raddr (col),
    .rdata (upper_rd)
  );

  logic                          s1_dn_ready;
  wes_token_t                    tok1;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [LAP_BITS-1:0]    lap;
  logic signed [SAMPLE_BITS-1:0] left_t;
  logic signed [SAMPLE_BITS-1:0] right_t;
  logic signed [SAMPLE_BITS-1:0] up_t;
  logic signed [SAMPLE_BITS-1:0] c_t;

  wes_pipe_cell u_cell_read (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cells.valid),
    .up_ready (cells.ready),
    .up_data  (tok0),
    .dn_valid (s1_valid),
    .dn_ready (s1_dn_ready),
    .dn_data  (s1_tok)
  );

  always_comb begin
    c_t     = $signed(mid_c_rd);
    left_t  = s1_tok.left_en ? left_sample : '0;
    right_t = s1_tok.right_en ? $signed(mid_r_rd) : '0;
    up_t    = s1_tok.up_en ? $signed(upper_rd) : '0;
    lap     = LAP_BITS'(left_t) + LAP_BITS'(right_t) + LAP_BITS'(up_t)
            + LAP_BITS'(s1_tok.down) - (LAP_BITS'(c_t) <<< 2);
    tok1     = s1_tok;
    tok1.c   = c_t;
    tok1.p   = $signed(prev_rd);
    tok1.acc = ACC_BITS'(lap);
  end

  assign s1_fire = s1_valid && s1_dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sample <= '0;
    end else if (s1_fire) begin
      left_sample <= c_t;
    end
  end

  logic                          s2_valid;
  logic                          s2_dn_ready;
  wes_token_t                    s2_tok;
  wes_token_t                    tok2;
  logic signed [GAIN_BITS:0]     gain_s;
  logic signed [LAP_BITS-1:0]    lap_s2;
  logic signed [ACC_BITS-1:0]    prod;

  wes_pipe_cell u_cell_lap (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s1_dn_ready),
    .up_data  (tok1),
    .dn_valid (s2_valid),
    .dn_ready (s2_dn_ready),
    .dn_data  (s2_tok)
  );

  always_comb begin
    gain_s   = $signed({1'b0, wave_gain});
    lap_s2   = s2_tok.acc[LAP_BITS-1:0];
    prod     = gain_s * lap_s2;
    tok2     = s2_tok;
    tok2.acc = prod;
  end

  logic                          s3_valid;
  logic                          s3_dn_ready;
  wes_token_t                    s3_tok;
  wes_token_t                    tok3;
  logic signed [ACC_BITS-1:0]    biased;
  logic signed [ACC_BITS-1:0]    rnd;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          out_up_ready;

  wes_pipe_cell u_cell_mul (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (s2_dn_ready),
    .up_data  (tok2),
    .dn_valid (s3_valid),
    .dn_ready (s3_dn_ready),
    .dn_data  (s3_tok)
  );

  always_comb begin
    biased = s3_tok.acc + ACC_BITS'(ROUND_BIAS);
    rnd    = biased >>> GAIN_BITS;
    sum    = SUM_BITS'(rnd) + (SUM_BITS'(s3_tok.c) <<< 1) - SUM_BITS'(s3_tok.p);
    if (sum > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat = sum[SAMPLE_BITS-1:0];
    end
    tok3     = s3_tok;
    tok3.acc = ACC_BITS'(sat);
  end

  assign s3_dn_ready = !s3_tok.has_out || out_up_ready;

  logic       out_valid;
  wes_token_t out_tok;

  wes_pipe_cell u_cell_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s3_valid && s3_tok.has_out),
    .up_ready (out_up_ready),
    .up_data  (tok3),
    .dn_valid (out_valid),
    .dn_ready (results.ready),
    .dn_data  (out_tok)
  );

  assign results.valid        = out_valid;
  assign results.new_value    = out_tok.acc[SAMPLE_BITS-1:0];
  assign results.end_of_frame = out_tok.eof;

  `WES_ASSERT_IMP(a_empty_takes_beat, clk, rst, !s1_valid, cells.ready)
  `WES_ASSERT_NXT(a_first_row_silent, clk, rst, in_fire && row_count == '0,
                  s1_valid && !s1_tok.has_out)
  `WES_ASSERT_NXT(a_frame_wraps, clk, rst, in_fire && eof_now,
                  column_count == '0 && row_count == '0)
  `WES_ASSERT_IMP(a_result_is_real, clk, rst, out_valid, out_tok.has_out)

endmodule

@@ rtl/core/wes_line_ram.sv @@
module wes_line_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/wes_pipe_cell.sv @@
module wes_pipe_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  wes_pkg::wes_token_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output wes_pkg::wes_token_t dn_data
);
  import wes_pkg::*;

  logic       valid;
  wes_token_t data;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= up_data;
    end
  end

endmodule

@@ tb/tb_wave_equation_stencil_step.sv @@
`timescale 1ns / 1ps

module tb_wave_equation_stencil_step;
  import wes_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CELLS   = 1550;
  localparam int CALM_AFTER     = 1300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [SAMPLE_BITS-1:0] prev;
    logic                          flush;
  } cell_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] height;
    logic                          end_of_frame;
  } height_beat_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  wes_cell_if   cells_if ();
  wes_result_if results_if ();

  wave_equation_stencil_step dut (
    .clk          (clk),
    .rst          (rst),
    .cells        (cells_if),
    .results      (results_if),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // stencil predictor state
  logic signed [SAMPLE_BITS-1:0] upper_row   [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] middle_row  [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] middle_prev [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] prior_centre;
  int unsigned                   col_pos;
  int unsigned                   row_pos;
  logic [CNT_BITS-1:0]           cols_reg;
  logic [CNT_BITS-1:0]           rows_reg;
  logic [GAIN_BITS-1:0]          gain_reg;
  height_beat_t                  expected_heights[$];

  // stimulus side
  cell_beat_t          pending_cells[$];
  cell_beat_t          next_beat;
  logic [CNT_BITS-1:0] gen_cols;
  logic [CNT_BITS-1:0] gen_rows;
  int unsigned         gen_col;
  int unsigned         gen_row;
  bit                  idling;
  int                  send_gap;
  int                  take_gap;

  bit cell_fire;
  bit height_fire;
  int stall_cycles;
  int mismatches;
  int cells_queued;
  int heights_seen;
  int frames_sent;
  int reg_writes;

  function automatic int unsigned clamp_size(logic [CNT_BITS-1:0] raw, int unsigned hi);
    if (raw < 2) return 2;
    if (raw > hi) return hi;
    return raw;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_GRID_COLUMNS: cols_reg = data[CNT_BITS-1:0];
      REG_GRID_ROWS:    rows_reg = data[CNT_BITS-1:0];
      REG_WAVE_GAIN:    gain_reg = data[GAIN_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void advance_stencil(cell_beat_t beat);
    int unsigned                   ncols;
    int unsigned                   nrows;
    int unsigned                   col;
    bit                            last_col;
    bit                            pad_row;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [SAMPLE_BITS-1:0] prev;
    logic signed [SAMPLE_BITS-1:0] c;
    logic signed [SAMPLE_BITS-1:0] p;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] up;
    longint                        lap;
    longint                        prod;
    longint                        val;
    longint                        smax;
    height_beat_t                  res;
    ncols = clamp_size(cols_reg, MAX_COLUMNS);
    nrows = clamp_size(rows_reg, MAX_ROWS);
    col = (col_pos >= ncols) ? ncols - 1 : col_pos;
    last_col = (col == ncols - 1);
    pad_row = (row_pos >= nrows);
    smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    cur = beat.cur;
    prev = beat.prev;
    if (beat.flush || pad_row) begin
      cur = '0;
      prev = '0;
    end
    if (row_pos >= 1) begin
      c = middle_row[col];
      p = middle_prev[col];
      left = (col > 0) ? prior_centre : '0;
      right = (!last_col && col + 1 < MAX_COLUMNS) ? middle_row[col + 1] : '0;
      up = (row_pos >= 2) ? upper_row[col] : '0;
      lap = longint'(left) + longint'(right) + longint'(up) + longint'(cur)
            - 4 * longint'(c);
      prod = longint'(gain_reg) * lap;
      val = 2 * longint'(c) - longint'(p) + ((prod + ROUND_BIAS) >>> GAIN_BITS);
      if (val > smax) val = smax;
      if (val < -smax - 1) val = -smax - 1;
      res.height = SAMPLE_BITS'(val);
      res.end_of_frame = pad_row && last_col;
      expected_heights.push_back(res);
      prior_centre = c;
    end else begin
      prior_centre = middle_row[col];
    end
    upper_row[col] = middle_row[col];
    middle_row[col] = cur;
    middle_prev[col] = prev;
    if (last_col) begin
      col_pos = 0;
      row_pos = pad_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  task automatic check_height();
    height_beat_t want;
    if (expected_heights.size() == 0) begin
      report_mismatch($sformatf("result beat %0d with nothing expected", heights_seen));
    end else begin
      want = expected_heights.pop_front();
      if (results_if.new_value !== want.height)
        report_mismatch($sformatf("beat %0d new_value %0d, want %0d", heights_seen,
                                  results_if.new_value, want.height));
      if (results_if.end_of_frame !== want.end_of_frame)
        report_mismatch($sformatf("beat %0d end_of_frame %0b, want %0b", heights_seen,
                                  results_if.end_of_frame, want.end_of_frame));
    end
    heights_seen++;
  endtask

  always @(posedge clk) begin
    cell_fire = !rst && cells_if.valid && cells_if.ready;
    height_fire = !rst && results_if.valid && results_if.ready;
    if (rst) begin
      col_pos = 0;
      row_pos = 0;
      prior_centre = '0;
      cols_reg = COLS_RESET;
      rows_reg = ROWS_RESET;
      gain_reg = GAIN_RESET;
      stall_cycles = 0;
    end else begin
      if (cfg_write_en) apply_reg(cfg_index, cfg_data);
      if (cell_fire)
        advance_stencil('{cells_if.cur_value, cells_if.prev_value, cells_if.flush});
      if (height_fire) check_height();
      if (cell_fire || height_fire) begin
        stall_cycles = 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 stall_cycles, expected_heights.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cells_if.valid <= 1'b0;
      results_if.ready <= 1'b0;
      send_gap = 0;
      take_gap = 0;
    end else begin
      if (!cells_if.valid || cell_fire) begin
        if (send_gap > 0) begin
          cells_if.valid <= 1'b0;
          send_gap--;
        end else if (pending_cells.size() == 0) begin
          cells_if.valid <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          cells_if.valid <= 1'b0;
        end else begin
          next_beat = pending_cells.pop_front();
          cells_if.valid <= 1'b1;
          cells_if.cur_value <= next_beat.cur;
          cells_if.prev_value <= next_beat.prev;
          cells_if.flush <= next_beat.flush;
        end
      end
      if (take_gap > 0) begin
        results_if.ready <= 1'b0;
        take_gap--;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(1, 11) - 1;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(wes_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_GRID_COLUMNS: gen_cols = data[CNT_BITS-1:0];
      REG_GRID_ROWS:    gen_rows = data[CNT_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // hold until every beat is out and every result is back, then let the pipe drain
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cells.size() != 0 || cells_if.valid || expected_heights.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_cell(logic signed [SAMPLE_BITS-1:0] cur,
                                     logic signed [SAMPLE_BITS-1:0] prev, logic flush);
    int unsigned ncols;
    int unsigned nrows;
    int unsigned col;
    ncols = clamp_size(gen_cols, MAX_COLUMNS);
    nrows = clamp_size(gen_rows, MAX_ROWS);
    col = (gen_col >= ncols) ? ncols - 1 : gen_col;
    pending_cells.push_back('{cur, prev, flush});
    cells_queued++;
    if (col == ncols - 1) begin
      gen_col = 0;
      if (gen_row >= nrows) begin
        gen_row = 0;
        frames_sent++;
      end else begin
        gen_row++;
      end
    end else begin
      gen_col = col + 1;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_height();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic void queue_random_cell();
    queue_cell(random_height(), random_height(), $urandom_range(0, 15) == 0);
  endfunction

  function automatic void finish_frame();
    do queue_random_cell(); while (gen_col != 0 || gen_row != 0);
  endfunction

  function automatic int unsigned frame_cells();
    return clamp_size(gen_cols, MAX_COLUMNS) * (clamp_size(gen_rows, MAX_ROWS) + 1);
  endfunction

  initial begin
    int unsigned         len;
    int unsigned         k;
    int                  directed_cells;
    int                  phase_no;
    logic [CNT_BITS-1:0] new_cols;
    logic [CNT_BITS-1:0] new_rows;
    logic [GAIN_BITS-1:0] new_gain;
    cells_if.valid = 1'b0;
    cells_if.cur_value = '0;
    cells_if.prev_value = '0;
    cells_if.flush = 1'b0;
    results_if.ready = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = REG_GRID_COLUMNS;
    cfg_data = '0;
    gen_cols = COLS_RESET;
    gen_rows = ROWS_RESET;
    gen_col = 0;
    gen_row = 0;
    idling = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // saturating gain, extremes, flush inside the grid, padding with and without flush
    settle();
    write_reg(REG_GRID_COLUMNS, 16'd3);
    write_reg(REG_GRID_ROWS, 16'd2);
    write_reg(REG_WAVE_GAIN, 16'hffff);
    queue_cell(16'sh7fff, 16'sh8000, 1'b0);
    queue_cell(16'sh8000, 16'sh7fff, 1'b0);
    queue_cell(16'sh7fff, 16'sh7fff, 1'b0);
    queue_cell(16'sh8000, 16'sh8000, 1'b0);
    queue_cell(16'sd12345, -16'sd5, 1'b1);
    queue_cell(16'sh7fff, 16'sh0000, 1'b0);
    queue_cell(16'sd1, 16'sd2, 1'b0);
    queue_cell(-16'sd1, 16'sd5, 1'b1);
    queue_cell(16'sh7fff, 16'sh8000, 1'b0);

    // sizes below range clamp to two, zero gain
    settle();
    write_reg(REG_GRID_COLUMNS, 16'd0);
    write_reg(REG_GRID_ROWS, 16'd1);
    write_reg(REG_WAVE_GAIN, 16'h0000);
    queue_cell(16'sh7fff, 16'sh8000, 1'b0);
    queue_cell(16'sh8000, 16'sh7fff, 1'b0);
    queue_cell(16'sh7fff, 16'sh7fff, 1'b0);
    queue_cell(16'sh8000, 16'sh8000, 1'b0);
    queue_cell(16'sh0000, 16'sh0000, 1'b1);
    queue_cell(16'sh7fff, 16'sh0000, 1'b0);

    // rows cut below the current row mid-frame: next row pads
    settle();
    write_reg(REG_GRID_COLUMNS, 16'd2);
    write_reg(REG_GRID_ROWS, 16'd3);
    write_reg(REG_WAVE_GAIN, GAIN_RESET);
    repeat (6) queue_random_cell();
    settle();
    write_reg(REG_GRID_ROWS, 16'd2);
    finish_frame();

    directed_cells = cells_queued;
    phase_no = 0;
    while (cells_queued - directed_cells < RANDOM_CELLS) begin
      settle();
      idling = (cells_queued - directed_cells < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      phase_no++;
      if (phase_no == 1) begin
        new_cols = 9'd300;
        new_rows = 9'd0;
      end else if (phase_no == 3) begin
        new_cols = 9'd1;
        new_rows = 9'd511;
      end else begin
        new_cols = ($urandom_range(0, 9) == 0) ? CNT_BITS'($urandom_range(0, 1))
                                               : CNT_BITS'($urandom_range(2, 12));
        new_rows = ($urandom_range(0, 9) == 0) ? CNT_BITS'($urandom_range(0, 1))
                                               : CNT_BITS'($urandom_range(2, 6));
      end
      case ($urandom_range(0, 5))
        0: new_gain = '0;
        1: new_gain = '1;
        2: new_gain = GAIN_RESET;
        3: new_gain = GAIN_BITS'($urandom_range(0, 8191));
        default: new_gain = GAIN_BITS'($urandom());
      endcase
      write_reg(REG_GRID_COLUMNS, {7'($urandom()), new_cols});
      write_reg(REG_GRID_ROWS, {7'($urandom()), new_rows});
      write_reg(REG_WAVE_GAIN, new_gain);
      len = frame_cells();
      if (len <= 64 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, len - 1);
        repeat (k) queue_random_cell();
        settle();
        case ($urandom_range(0, 2))
          0: write_reg(REG_GRID_COLUMNS,
                       16'($urandom_range(2, clamp_size(gen_cols, MAX_COLUMNS))));
          1: write_reg(REG_GRID_ROWS, 16'($urandom_range(2, clamp_size(gen_rows, MAX_ROWS))));
          default: write_reg(REG_WAVE_GAIN, 16'($urandom()));
        endcase
      end
      finish_frame();
    end

    settle();
    $display("covered %0d frames, %0d cell beats, %0d result beats checked",
             frames_sent, cells_queued, heights_seen);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/wes_pkg.sv
rtl/core/wes_if.sv
rtl/core/wes_line_ram.sv
rtl/core/wes_pipe_cell.sv
rtl/core/wave_equation_stencil_step.sv
tb/tb_wave_equation_stencil_step.sv
